// ----- rtl/ttbi_pkg.sv -----
// Types and constants shared by the tagged text block indexer.
`default_nettype none
package ttbi_pkg;

  localparam int NUM_W = 14;
  localparam int OUT_OFF_W = 24;
  localparam int MAXB_W = 11;
  localparam int EPOCH_W = 8;
  localparam int FIELD_BYTES = 4;

  localparam logic [MAXB_W-1:0] MAX_BLOCKS_RST = 11'd1024;

  localparam logic [7:0] CH_OPEN = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [1:0] ST_STORED = 2'd0;
  localparam logic [1:0] ST_TAKEN = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_END = 2'd3;

  typedef enum logic [1:0] {
    PH_SEEK_OPEN = 2'd0,
    PH_NUMBER = 2'd1,
    PH_SEEK_CLOSE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic last;
  } in_t;

  typedef struct packed {
    logic [NUM_W-1:0] block_number;
    logic [OUT_OFF_W-1:0] body_offset;
    logic [1:0] status;
  } out_t;

  typedef struct packed {
    logic lookup;
    logic resolve;
    logic end_res;
    logic file_end;
  } parse_ev_t;

endpackage
`default_nettype wire

// ----- rtl/ttbi_parser.sv -----
// Byte scanner: record framing, number accumulation and file offset.
`default_nettype none
module ttbi_parser
  import ttbi_pkg::*;
#(
  parameter int OFFSET_BITS = 24
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic accept,
  input wire in_t byte_in,
  output parse_ev_t ev,
  output logic [NUM_W-1:0] lookup_num,
  output logic [NUM_W-1:0] res_number,
  output logic [OUT_OFF_W-1:0] res_offset
);

  phase_t phase, phase_next;
  logic [2:0] field_count;
  logic [NUM_W-1:0] number_accum;
  logic digits_stopped;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic scan_ended;

  logic [7:0] b;
  logic is_end, is_digit, take_digit, active, in_field;
  logic [NUM_W-1:0] accum_next;
  logic [OFFSET_BITS-1:0] off_inc, off_sel;
  logic [OFFSET_BITS+OUT_OFF_W-1:0] off_wide;

  assign b = byte_in.data_byte;
  assign is_end = byte_in.last || (b == 8'd0);
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign take_digit = !digits_stopped && is_digit;
  assign accum_next = NUM_W'(number_accum * NUM_W'(10) + NUM_W'(b - CH_ZERO));
  assign active = accept && !scan_ended && !is_end;
  assign in_field = field_count < 3'(FIELD_BYTES);
  assign off_inc = byte_offset + OFFSET_BITS'(1);

  // number as it stands after this byte, for the early table read
  assign lookup_num = take_digit ? accum_next : number_accum;
  assign res_number = number_accum;

  assign off_sel = ev.resolve ? off_inc : byte_offset;
  assign off_wide = {{OUT_OFF_W{1'b0}}, off_sel};
  assign res_offset = off_wide[OUT_OFF_W-1:0];

  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (byte_in.last) begin
        phase_next = PH_SEEK_OPEN;
      end else if (!scan_ended && b != 8'd0) begin
        unique case (phase)
          PH_NUMBER: begin
            if (!in_field) phase_next = PH_SEEK_CLOSE;
          end
          PH_SEEK_CLOSE: begin
            if (b == CH_CLOSE) phase_next = PH_SEEK_OPEN;
          end
          default: begin
            phase_next = (b == CH_OPEN) ? PH_NUMBER : PH_SEEK_OPEN;
          end
        endcase
      end
    end
  end

  always_comb begin
    ev.file_end = accept && byte_in.last;
    ev.end_res = accept && !scan_ended && is_end;
    ev.lookup = active && (phase == PH_NUMBER) && (field_count == 3'(FIELD_BYTES - 1));
    ev.resolve = active && (phase == PH_NUMBER) && !in_field;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEEK_OPEN;
      field_count <= '0;
      number_accum <= '0;
      digits_stopped <= 1'b0;
      byte_offset <= '0;
      scan_ended <= 1'b0;
    end else begin
      phase <= phase_next;
      if (accept) begin
        if (byte_in.last) begin
          field_count <= '0;
          number_accum <= '0;
          digits_stopped <= 1'b0;
          byte_offset <= '0;
          scan_ended <= 1'b0;
        end else begin
          byte_offset <= off_inc;
          if (!scan_ended) begin
            if (b == 8'd0) begin
              scan_ended <= 1'b1;
            end else if (phase == PH_NUMBER && in_field) begin
              if (take_digit) number_accum <= accum_next;
              else digits_stopped <= 1'b1;
              field_count <= field_count + 3'd1;
            end else if (phase == PH_SEEK_OPEN && b == CH_OPEN) begin
              field_count <= '0;
              number_accum <= '0;
              digits_stopped <= 1'b0;
            end
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ttbi_table.sv -----
// Taken-entry table: epoch-tagged memory with clearing pass and range check.
`default_nettype none
module ttbi_table
  import ttbi_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic [MAXB_W-1:0] max_blocks,
  input wire parse_ev_t ev,
  input wire logic [NUM_W-1:0] lookup_num,
  input wire logic [NUM_W-1:0] res_num,
  output logic busy,
  output logic taken,
  output logic in_range
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [NUM_W:0] DEPTH_LIM = (NUM_W + 1)'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  logic [EPOCH_W-1:0] mem [TABLE_DEPTH];
  logic [EPOCH_W-1:0] rd_tag;
  logic [EPOCH_W-1:0] epoch;
  logic sweeping;
  logic [IDX_W-1:0] sweep_addr;

  logic [NUM_W:0] max_ext, lim;
  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [EPOCH_W-1:0] wr_tag;

  assign max_ext = (NUM_W + 1)'(max_blocks);
  assign lim = (max_ext > DEPTH_LIM) ? DEPTH_LIM : max_ext;
  assign in_range = {1'b0, res_num} < lim;
  // an entry is taken when it carries the tag of the current file
  assign taken = (rd_tag == epoch);
  assign busy = sweeping;

  always_comb begin
    if (sweeping) begin
      wr_en = 1'b1;
      wr_addr = sweep_addr;
      wr_tag = '0;
    end else begin
      wr_en = ev.resolve && in_range && !taken;
      wr_addr = res_num[IDX_W-1:0];
      wr_tag = epoch;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_tag;
  end

  always_ff @(posedge clk) begin
    if (ev.lookup) rd_tag <= mem[lookup_num[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping <= 1'b1;
      sweep_addr <= '0;
      epoch <= '0;
    end else if (sweeping) begin
      sweep_addr <= sweep_addr + IDX_W'(1);
      if (sweep_addr == LAST_IDX) begin
        sweeping <= 1'b0;
        epoch <= EPOCH_W'(1);
      end
    end else if (ev.file_end) begin
      // advance the file tag; clear the memory once the tags run out
      if (epoch == '1) begin
        sweeping <= 1'b1;
        sweep_addr <= '0;
      end else begin
        epoch <= epoch + EPOCH_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ttbi_out_queue.sv -----
// Two-entry result queue: output register plus skid stage.
`default_nettype none
module ttbi_out_queue
  import ttbi_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire out_t push_data,
  output logic full,
  output logic out_valid,
  input wire logic out_ready,
  output out_t out_data
);

  logic [1:0] count;
  out_t skid;
  logic pop;

  assign pop = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) out_data <= skid;
      else if (push) out_data <= push_data;
    end else if (push) begin
      if (count == 2'd0) out_data <= push_data;
      else skid <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tagged_text_block_indexer.sv -----
// Top level of the tagged text block indexer.
// Takes one file byte per clock while no clearing pass runs and the queue has room,
// and pushes each record's result into the output queue as its skipped fifth byte
// is taken; this two-entry queue lets bytes keep flowing while a result waits. The
// taken table is one memory of TABLE_DEPTH epoch tags read one byte ahead of each
// resolve, so the read-modify-write costs no stall. After reset, and after every
// 255th end of file, a clearing pass over all TABLE_DEPTH entries runs during which
// no byte is taken; max_blocks can be written at any time through the cfg channel.
`default_nettype none
module tagged_text_block_indexer
  import ttbi_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int OFFSET_BITS = 24
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  output logic in_ready,
  input wire in_t in_data,
  output logic out_valid,
  input wire logic out_ready,
  output out_t out_data,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic [MAXB_W-1:0] cfg_data
);

  logic [MAXB_W-1:0] max_blocks;
  logic accept, busy, q_full, taken, in_range;
  parse_ev_t ev;
  logic [NUM_W-1:0] lookup_num, res_number;
  logic [OUT_OFF_W-1:0] res_offset;
  out_t result;

  assign cfg_ready = 1'b1;
  assign in_ready = !busy && !q_full;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_blocks <= MAX_BLOCKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_blocks <= cfg_data;
    end
  end

  ttbi_parser #(.OFFSET_BITS(OFFSET_BITS)) u_parser (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .byte_in(in_data),
    .ev(ev),
    .lookup_num(lookup_num),
    .res_number(res_number),
    .res_offset(res_offset)
  );

  ttbi_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk(clk),
    .rst(rst),
    .max_blocks(max_blocks),
    .ev(ev),
    .lookup_num(lookup_num),
    .res_num(res_number),
    .busy(busy),
    .taken(taken),
    .in_range(in_range)
  );

  always_comb begin
    result.body_offset = res_offset;
    if (ev.end_res) begin
      result.block_number = '0;
      result.status = ST_END;
    end else begin
      result.block_number = res_number;
      if (!in_range) result.status = ST_RANGE;
      else if (taken) result.status = ST_TAKEN;
      else result.status = ST_STORED;
    end
  end

  ttbi_out_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(ev.end_res || ev.resolve),
    .push_data(result),
    .full(q_full),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

// ----- sim/tagged_text_block_indexer_test.sv -----
// Self-checking testbench for the tagged text block indexer.
`timescale 1ns / 100ps

module tagged_text_block_indexer_test;
  import ttbi_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int OFFSET_BITS = 24;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam logic [7:0] CH_COLON = 8'h3A;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MAXB_W-1:0] cfg_data = '0;

  // Expected scanner state, kept in step with every accepted byte
  phase_t scan_phase = PH_SEEK_OPEN;
  logic [2:0] field_cnt = '0;
  logic [NUM_W-1:0] number_acc = '0;
  logic digits_done = 1'b0;
  logic [OFFSET_BITS-1:0] file_offset = '0;
  logic scan_stopped = 1'b0;
  bit taken_bits[TABLE_DEPTH];
  logic [MAXB_W-1:0] max_blocks_cfg = MAX_BLOCKS_RST;

  out_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int ready_roll;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;

  always #6 clk = ~clk;

  tagged_text_block_indexer #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .OFFSET_BITS(OFFSET_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  function automatic void start_new_file();
    foreach (taken_bits[i]) taken_bits[i] = 1'b0;
    scan_phase = PH_SEEK_OPEN;
    field_cnt = '0;
    number_acc = '0;
    digits_done = 1'b0;
    file_offset = '0;
    scan_stopped = 1'b0;
  endfunction

  // Advance the expected scanner by one byte; queue the result it gives, if any.
  function automatic void index_byte(input logic [7:0] b, input logic lst);
    logic [OFFSET_BITS-1:0] off;
    logic [MAXB_W-1:0] lim;
    out_t res;
    off = file_offset;
    file_offset = off + 1'b1;
    res = '0;
    if (scan_stopped) begin
      if (lst) start_new_file();
    end else if (lst || b == 8'h00) begin
      res.body_offset = off;
      res.status = ST_END;
      pending_results.push_back(res);
      if (lst) start_new_file();
      else scan_stopped = 1'b1;
    end else begin
      case (scan_phase)
        PH_NUMBER: begin
          if (field_cnt < FIELD_BYTES) begin
            if (!digits_done && b >= CH_ZERO && b <= CH_NINE)
              number_acc = number_acc * 14'd10 + NUM_W'(b - CH_ZERO);
            else
              digits_done = 1'b1;
            field_cnt = field_cnt + 1'b1;
          end else begin
            // Fifth byte is skipped; the body starts right after it
            scan_phase = PH_SEEK_CLOSE;
            lim = (max_blocks_cfg > TABLE_DEPTH) ? MAXB_W'(TABLE_DEPTH) : max_blocks_cfg;
            res.block_number = number_acc;
            res.body_offset = off + 1'b1;
            if (number_acc >= lim) begin
              res.status = ST_RANGE;
            end else if (taken_bits[number_acc]) begin
              res.status = ST_TAKEN;
            end else begin
              taken_bits[number_acc] = 1'b1;
              res.status = ST_STORED;
            end
            pending_results.push_back(res);
          end
        end
        PH_SEEK_CLOSE: begin
          if (b == CH_CLOSE) scan_phase = PH_SEEK_OPEN;
        end
        default: begin
          scan_phase = PH_SEEK_OPEN;
          if (b == CH_OPEN) begin
            scan_phase = PH_NUMBER;
            field_cnt = '0;
            number_acc = '0;
            digits_done = 1'b0;
          end
        end
      endcase
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (in_quiet || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic logic [7:0] random_text_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return CH_OPEN;
    if (r == 1) return CH_CLOSE;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic check_result(input out_t got);
    out_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result: number %0d offset %0d status %0d", $time,
               got.block_number, got.body_offset, got.status);
      errors++;
    end else begin
      want = pending_results.pop_front();
      if (got.block_number !== want.block_number) begin
        $display("%0t: block_number expected %0d, got %0d", $time,
                 want.block_number, got.block_number);
        errors++;
      end
      if (got.body_offset !== want.body_offset) begin
        $display("%0t: body_offset expected %0d, got %0d", $time,
                 want.body_offset, got.body_offset);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        errors++;
      end
    end
  endtask

  // Result side: check each accepted result, then pick the next ready value
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (out_quiet) begin
        out_ready <= 1'b1;
      end else begin
        ready_roll = $urandom_range(0, 99);
        if (ready_roll < 4) stall_left = $urandom_range(12, 40);
        out_ready <= (ready_roll >= 30);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tagged_text_block_indexer_test: done, errors");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= in_t'{data_byte: b, last: lst};
    do @(posedge clk); while (!in_ready);
    index_byte(b, lst);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // Hold the sender until every queued result is out and the pipeline is quiet
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_blocks(input logic [MAXB_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_blocks_cfg = value;
  endtask

  task automatic send_record();
    int num;
    logic [7:0] digits[5];
    num = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9999) : $urandom_range(0, 40);
    digits[0] = CH_ZERO + 8'(num / 1000 % 10);
    digits[1] = CH_ZERO + 8'(num / 100 % 10);
    digits[2] = CH_ZERO + 8'(num / 10 % 10);
    digits[3] = CH_ZERO + 8'(num % 10);
    if ($urandom_range(0, 5) == 0) digits[$urandom_range(0, 3)] = random_text_byte();
    digits[4] = ($urandom_range(0, 7) == 0) ? random_text_byte() : CH_COLON;
    send_byte(CH_OPEN, 1'b0);
    foreach (digits[i]) send_byte(digits[i], 1'b0);
    repeat ($urandom_range(0, 6)) send_byte(random_text_byte(), 1'b0);
    if ($urandom_range(0, 4) != 0) send_byte(CH_CLOSE, 1'b0);
  endtask

  task automatic send_random_file();
    int n_seg;
    int kind;
    bit done;
    in_quiet = ($urandom_range(0, 3) == 0);
    out_quiet = ($urandom_range(0, 3) == 0);
    n_seg = $urandom_range(1, 8);
    done = 1'b0;
    for (int s = 0; s < n_seg && !done; s++) begin
      kind = $urandom_range(0, 99);
      if (kind < 62) begin
        send_record();
      end else if (kind < 82) begin
        repeat ($urandom_range(1, 5)) send_byte(random_text_byte(), 1'b0);
      end else if (kind < 95) begin
        // Record cut off by a zero byte or by the end of the file
        send_byte(CH_OPEN, 1'b0);
        repeat ($urandom_range(0, 4)) send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        if ($urandom_range(0, 1) == 0) begin
          send_byte(8'h00, 1'b0);
        end else begin
          send_byte(8'($urandom_range(0, 255)), 1'b1);
          done = 1'b1;
        end
      end else begin
        send_byte(8'h00, 1'b0);
      end
    end
    if (!done) send_byte(8'($urandom_range(0, 255)), 1'b1);
    if ($urandom_range(0, 19) == 0) wait_drained();
  endtask

  task automatic test_record_forms();
    send_text("[0000:[]");
    // A bracket among the number bytes stops the digits
    send_text("[00]0:");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_OPEN, 1'b1);
    // New file: entry 0 is free again; then a record cut off by the last byte
    send_text("[0000:][7");
    send_byte(8'h00, 1'b1);
    send_text("[0007");
    send_byte(8'h00, 1'b0);
    send_byte(CH_CLOSE, 1'b1);
  endtask

  task automatic test_max_blocks();
    write_max_blocks(11'd0);
    send_text("[0000:");
    send_byte(8'h00, 1'b1);
    write_max_blocks(11'd1);
    send_text("[0000:][0001:");
    send_byte(8'h00, 1'b1);
    write_max_blocks(11'd2047);
    send_text("[1023:][1024:][9999:");
    send_byte(8'h00, 1'b1);
    write_max_blocks(MAX_BLOCKS_RST);
    send_text("[1023:][1024:");
    send_byte(8'h00, 1'b1);
  endtask

  // Run enough files to force the table's periodic clear and check a reused entry
  task automatic test_table_clearing();
    for (int f = 0; f < 270; f++) begin
      in_quiet = ($urandom_range(0, 1) == 0);
      if (f % 32 == 0) send_text("[0007:");
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic test_random_files();
    int target;
    for (int round = 0; round < 3; round++) begin
      if (round == 0) write_max_blocks(11'($urandom_range(1, 1024)));
      else if (round == 1) write_max_blocks(11'd16);
      else write_max_blocks(11'd2047);
      target = items_sent + 240;
      while (items_sent < target) send_random_file();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_record_forms();
    test_max_blocks();
    test_table_clearing();
    test_random_files();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("tagged_text_block_indexer_test: done, clean");
    else
      $display("tagged_text_block_indexer_test: done, errors");
    $finish;
  end

endmodule
